[src/jse_pkg.sv]
// jse_pkg: shared types and character codes for the json string escaper
// used by jse_front, jse_queue, jse_back and json_string_escaper
package jse_pkg;

    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_ZERO      = 8'h30;
    localparam logic [7:0] C_LET_U     = 8'h75;
    localparam logic [7:0] C_LET_B     = 8'h62;
    localparam logic [7:0] C_LET_T     = 8'h74;
    localparam logic [7:0] C_LET_N     = 8'h6E;
    localparam logic [7:0] C_LET_F     = 8'h66;
    localparam logic [7:0] C_LET_R     = 8'h72;
    localparam logic [7:0] C_HEX_ALPHA = 8'h37;  // 'A' - 10
    localparam logic [3:0] C_NIBBLE    = 4'hF;

    typedef enum logic [1:0] {
        K_PLAIN,   // byte passes through
        K_ESC,     // backslash plus a second character
        K_UNI,     // backslash u 0 0 hex hex
        K_CLOSE    // closing quote
    } t_kind;

    // one classified input item
    typedef struct packed {
        logic       open_q;  // emit an opening quote first
        t_kind      kind;
        logic [7:0] ch;      // raw byte, or character after the backslash
    } t_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'h0, nib & C_NIBBLE};
        if (nib < 4'd10) begin
            hex_char = C_ZERO + v;
        end else begin
            hex_char = C_HEX_ALPHA + v;
        end
    endfunction

endpackage

[src/jse_front.sv]
// jse_front: accepts input transfers, tracks whether a string is open and
// classifies each byte; depends on jse_pkg
module jse_front
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_cmd,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_desc      o_desc
);

    logic r_inside;
    logic n_inside;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_desc.open_q = !r_inside;
        o_desc.kind   = K_PLAIN;
        o_desc.ch     = i_byte;
        if (i_cmd) begin
            o_desc.kind = K_CLOSE;
        end else begin
            unique case (i_byte)
                8'h08: begin o_desc.kind = K_ESC; o_desc.ch = C_LET_B; end
                8'h09: begin o_desc.kind = K_ESC; o_desc.ch = C_LET_T; end
                8'h0A: begin o_desc.kind = K_ESC; o_desc.ch = C_LET_N; end
                8'h0C: begin o_desc.kind = K_ESC; o_desc.ch = C_LET_F; end
                8'h0D: begin o_desc.kind = K_ESC; o_desc.ch = C_LET_R; end
                C_QUOTE,
                C_BACKSLASH: begin
                    o_desc.kind = K_ESC;
                end
                default: begin
                    if (i_byte < 8'h20) begin
                        o_desc.kind = K_UNI;
                    end
                end
            endcase
        end
    end

    assign n_inside = o_push ? !i_cmd : r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
        end else begin
            r_inside <= n_inside;
        end
    end

endmodule

[src/jse_queue.sv]
// jse_queue: small register queue of classified items between front and back
// depends on jse_pkg for the item type
module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_desc o_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [AW:0]   r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[src/jse_back.sv]
// jse_back: takes classified queue items and, unless stalled, emits their
// escaped bytes one per cycle into an output register; depends on jse_pkg
module jse_back
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_desc      i_q_desc,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_end
);

    logic       r_have;
    t_desc      r_desc;
    logic [2:0] r_step;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol, r_oe;

    logic       adv;
    logic [2:0] j, cnt;
    logic [7:0] cur_byte;
    logic       cur_last, cur_end, is_open;

    assign adv = !r_ov || i_ready;

    always_comb begin
        is_open  = r_desc.open_q && (r_step == 3'd0);
        j        = r_step - {2'b00, r_desc.open_q};
        cur_end  = 1'b0;
        cur_byte = C_QUOTE;
        unique case (r_desc.kind)
            K_PLAIN: cnt = 3'd1;
            K_ESC:   cnt = 3'd2;
            K_UNI:   cnt = 3'd6;
            K_CLOSE: cnt = 3'd1;
            default: cnt = 3'd1;
        endcase
        if (!is_open) begin
            unique case (r_desc.kind)
                K_PLAIN: cur_byte = r_desc.ch;
                K_ESC:   cur_byte = (j == 3'd0) ? C_BACKSLASH : r_desc.ch;
                K_UNI: begin
                    unique case (j)
                        3'd0:    cur_byte = C_BACKSLASH;
                        3'd1:    cur_byte = C_LET_U;
                        3'd2,
                        3'd3:    cur_byte = C_ZERO;
                        3'd4:    cur_byte = hex_char(r_desc.ch[7:4]);
                        default: cur_byte = hex_char(r_desc.ch[3:0]);
                    endcase
                end
                K_CLOSE: begin
                    cur_byte = C_QUOTE;
                    cur_end  = 1'b1;
                end
                default: cur_byte = r_desc.ch;
            endcase
        end
        cur_last = (r_step == cnt + {2'b00, r_desc.open_q} - 3'd1);
    end

    // next item enters while the last byte of the current one is emitted
    assign o_pop = i_q_valid && (!r_have || (adv && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_step <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= r_have;
            end
            if (r_have && adv) begin
                r_step <= cur_last ? 3'd0 : r_step + 3'd1;
            end
            if (o_pop) begin
                r_have <= 1'b1;
            end else if (r_have && adv && cur_last) begin
                r_have <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_desc;
        end
        if (adv && r_have) begin
            r_ob <= cur_byte;
            r_ol <= cur_last;
            r_oe <= cur_end;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;
    assign o_end   = r_oe;

endmodule

[src/json_string_escaper.sv]
// json_string_escaper: top level, wires front, queue and back together
// depends on jse_pkg, jse_front, jse_queue and jse_back
//
// channel   direction  tdata            tuser          tlast
// s_axis    in         data_byte[7:0]   cmd            -
// m_axis    out        out_byte[7:0]    string_end     run_last
//
// a plain byte inside an open string yields one output byte, so one transfer per cycle
// while the output does not stall; an escape yields two bytes, a \u00XX form six,
// plus one for an opening quote; the back sequencer emits one per cycle unless stalled
// synchronous active-low reset closes any open string and empties the queue
// input stalls only when the queue is full; output stalls hold the output register
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] s_axis_tuser,   // [0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] m_axis_tuser,   // [0] string_end
    output logic       m_axis_tlast
);

    logic  push, pop, full, q_valid;
    t_desc f_desc, q_desc;

    jse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (s_axis_tuser[0]),
        .i_byte  (s_axis_tdata),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_desc  (f_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (f_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_end     (m_axis_tuser[0])
    );

endmodule
